// ----- src/header_length_tail_deframer_macros.svh -----
// Assertion macros used by the deframer core.
// Each one expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef HEADER_LENGTH_TAIL_DEFRAMER_MACROS_SVH
`define HEADER_LENGTH_TAIL_DEFRAMER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HLTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HLTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/hltd_pkg.sv -----
package hltd_pkg;

  // Frame layout: sync header, then a little-endian length, then info and tail
  localparam int unsigned HDR_BYTES  = 4;
  localparam int unsigned LEN_BYTES  = 2;
  localparam int unsigned BODY_START = HDR_BYTES + LEN_BYTES;
  localparam int unsigned BYTE_W     = 8;

  // Widths
  localparam int unsigned POS_W   = 17;
  localparam int unsigned LEN_W   = 16;
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned OUT_W   = 40;

  // Register indexes (byte address 4*i)
  localparam logic [2:0] REG_SYNC_PATTERN  = 3'd0;
  localparam logic [2:0] REG_TAIL_VALUE    = 3'd1;
  localparam logic [2:0] REG_MAX_INFO_LEN  = 3'd2;
  localparam logic [2:0] REG_MIN_INFO_LEN  = 3'd3;
  localparam logic [2:0] REG_HEAD_INFO_LEN = 3'd4;

  // Result kinds
  typedef enum logic [1:0] {
    EV_INFO     = 2'd0,
    EV_GOOD     = 2'd1,
    EV_BAD_TAIL = 2'd2
  } event_kind_t;

  // Configuration as seen by the parser
  typedef struct packed {
    logic [31:0]      sync_pattern;
    logic [7:0]       tail_value;
    logic [LEN_W-1:0] max_info_len;
    logic [LEN_W-1:0] min_info_len;
    logic [LEN_W-1:0] head_info_len;
  } cfg_t;

endpackage

// ----- src/header_length_tail_deframer.sv -----
// Each byte passes an input register and a result register, with the header/length/tail
// compare and the position counter update between them. Throughput: one byte per cycle
// while results are taken; a stalled result holds the input byte and stalls the input.
// Header, length and non-emitting bytes produce no result transfer.
// Reset (rst_n low, synchronous): parser hunts for the header, both stages empty,
// registers return to sync 0, tail 0, max 65535, min 1, head info 0.
module header_length_tail_deframer
  import hltd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // Configuration port
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready,
  // Byte stream in
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // rx_byte[7:0]
  // Events out
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,  // info_byte[7:0], info_index[23:8], payload_len[39:24]
  output logic [1:0]        out_tuser   // event_kind[1:0]
);

  cfg_t cfg;

  hltd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  hltd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- src/hltd_regs.sv -----
module hltd_regs
  import hltd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign reg_idx    = cfg_paddr[4:2];
  assign cfg        = cfg_r;

  // Write the addressed register on the access cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_pattern  <= '0;
      cfg_r.tail_value    <= '0;
      cfg_r.max_info_len  <= 16'hFFFF;
      cfg_r.min_info_len  <= 16'd1;
      cfg_r.head_info_len <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SYNC_PATTERN:  cfg_r.sync_pattern  <= cfg_pwdata;
        REG_TAIL_VALUE:    cfg_r.tail_value    <= cfg_pwdata[7:0];
        REG_MAX_INFO_LEN:  cfg_r.max_info_len  <= cfg_pwdata[LEN_W-1:0];
        REG_MIN_INFO_LEN:  cfg_r.min_info_len  <= cfg_pwdata[LEN_W-1:0];
        REG_HEAD_INFO_LEN: cfg_r.head_info_len <= cfg_pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back the addressed register
  always_comb begin
    unique case (reg_idx)
      REG_SYNC_PATTERN:  cfg_prdata = cfg_r.sync_pattern;
      REG_TAIL_VALUE:    cfg_prdata = {24'd0, cfg_r.tail_value};
      REG_MAX_INFO_LEN:  cfg_prdata = {16'd0, cfg_r.max_info_len};
      REG_MIN_INFO_LEN:  cfg_prdata = {16'd0, cfg_r.min_info_len};
      REG_HEAD_INFO_LEN: cfg_prdata = {16'd0, cfg_r.head_info_len};
      default:           cfg_prdata = '0;
    endcase
  end

endmodule

// ----- src/hltd_core.sv -----
`include "header_length_tail_deframer_macros.svh"

module hltd_core
  import hltd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // rx_byte
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,  // info_byte[7:0], info_index[23:8], payload_len[39:24]
  output logic [1:0]       out_tuser   // event_kind[1:0]
);

  // Input stage
  logic             in_v_r;
  logic [7:0]       in_byte_r;
  // Parser state
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  // Result stage
  logic             out_v_r;
  event_kind_t      kind_r;
  logic [7:0]       byte_r;
  logic [LEN_W-1:0] index_r;
  logic [LEN_W-1:0] plen_r;

  logic             proc_go;
  logic             emit;
  event_kind_t      ev_kind;
  logic [7:0]       ev_byte;
  logic [LEN_W-1:0] ev_index;
  logic [LEN_W-1:0] ev_plen;
  logic [LEN_W-1:0] len_cand;
  logic [POS_W-1:0] tail_pos;
  logic [POS_W-1:0] idx_full;
  logic [LEN_W-1:0] body_len;
  logic [7:0]       want;

  // Process the held byte whenever the result register can take a result
  assign proc_go   = in_v_r & (~out_v_r | out_tready);
  assign in_tready = ~in_v_r | proc_go;

  assign len_cand = {in_byte_r, len_r[7:0]};
  assign tail_pos = {1'b0, len_r} + POS_W'(BODY_START - 1);
  assign idx_full = pos_r - POS_W'(BODY_START);
  assign body_len = len_r - LEN_W'(1);
  assign want     = cfg.sync_pattern[{pos_r[1:0], 3'b000} +: BYTE_W];

  // Parse one byte: header hunt, length, info bytes, tail check
  always_comb begin
    pos_nxt  = pos_r;
    len_nxt  = len_r;
    emit     = 1'b0;
    ev_kind  = EV_INFO;
    ev_byte  = in_byte_r;
    ev_index = idx_full[LEN_W-1:0];
    ev_plen  = '0;
    if (pos_r < POS_W'(HDR_BYTES)) begin
      pos_nxt = (in_byte_r == want) ? pos_r + POS_W'(1) : '0;
    end else if (pos_r == POS_W'(HDR_BYTES)) begin
      len_nxt = {8'd0, in_byte_r};
      pos_nxt = POS_W'(HDR_BYTES + 1);
    end else if (pos_r == POS_W'(HDR_BYTES + 1)) begin
      len_nxt = len_cand;
      if (len_cand == '0 || len_cand > cfg.max_info_len || len_cand < cfg.min_info_len) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = POS_W'(BODY_START);
      end
    end else if (pos_r >= tail_pos) begin
      pos_nxt  = '0;
      emit     = 1'b1;
      ev_byte  = '0;
      ev_index = '0;
      if (in_byte_r != cfg.tail_value) begin
        ev_kind = EV_BAD_TAIL;
      end else begin
        ev_kind = EV_GOOD;
        ev_plen = (body_len > cfg.head_info_len) ? body_len - cfg.head_info_len : '0;
      end
    end else begin
      emit    = 1'b1;
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  // Input register: load on transfer, drop once processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
  end

  // Advance parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      len_r <= '0;
    end else if (proc_go) begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
    end
  end

  // Result register: hold until transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc_go) begin
      out_v_r <= emit;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && emit) begin
      kind_r  <= ev_kind;
      byte_r  <= ev_byte;
      index_r <= ev_index;
      plen_r  <= ev_plen;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {plen_r, index_r, byte_r};
  assign out_tuser  = kind_r;

  `HLTD_ASSERT_NOW(a_pos_within_frame, pos_r >= POS_W'(BODY_START), pos_r <= tail_pos, "frame position passed the tail")
  `HLTD_ASSERT_NEXT(a_tail_rehunts, proc_go && pos_r >= POS_W'(BODY_START) && pos_r >= tail_pos, pos_r == '0 && out_v_r, "tail byte did not end the frame")
  `HLTD_ASSERT_NEXT(a_input_held, in_v_r && !proc_go, in_v_r && $stable(in_byte_r), "held byte lost while stalled")

endmodule

// ----- bench/header_length_tail_deframer_tb.sv -----
`timescale 1ns / 100ps

module header_length_tail_deframer_tb;
  import hltd_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASES       = 10;
  localparam int unsigned PHASE_BYTES  = 38;
  localparam int unsigned LONGEST      = 40;
  localparam logic [2:0]  REG_SPARE    = 3'd5;

  // One result transfer, split into its fields
  typedef struct packed {
    event_kind_t kind;
    logic [7:0]  info_byte;
    logic [15:0] info_index;
    logic [15:0] payload_len;
  } ev_t;

  localparam ev_t NO_EV = '{EV_INFO, 8'h00, 16'h0000, 16'h0000};

  // Directed row: byte to send, and a hand-typed outcome where typed is set
  typedef struct {
    logic [7:0] rx;
    bit         typed;
    bit         emits;
    ev_t        ev;
  } dir_row_t;

  logic              clk;
  logic              rst_n       = 1'b0;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [ADDR_W-1:0] cfg_paddr   = '0;
  logic [DATA_W-1:0] cfg_pwdata  = '0;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;
  logic              in_tvalid   = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata    = '0;   // rx_byte[7:0]
  logic              out_tvalid;
  logic              out_tready  = 1'b0;
  logic [OUT_W-1:0]  out_tdata;          // info_byte[7:0], info_index[23:8], payload_len[39:24]
  logic [1:0]        out_tuser;          // event_kind[1:0]

  // Predictor state and its copy of the registers
  cfg_t             model_cfg;
  logic [POS_W-1:0] frame_pos;
  logic [LEN_W-1:0] info_len;

  ev_t         pending_events[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned bytes_sent;
  bit          quiet;
  dir_row_t    dir_tab[24];

  header_length_tail_deframer uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("header_length_tail_deframer_tb failed");
      $finish;
    end
  end

  function automatic bit length_ok(input logic [15:0] len);
    return len != 16'h0000 && len <= model_cfg.max_info_len && len >= model_cfg.min_info_len;
  endfunction

  // Advance the deframer state by one byte; return 1 when it yields a result
  function automatic bit deframe_byte(input logic [7:0] rx, output ev_t ev);
    logic [15:0] body;
    ev = NO_EV;
    // Hunt: match the sync header, drop to position zero on a miss
    if (frame_pos < HDR_BYTES) begin
      if (rx == model_cfg.sync_pattern[8*int'(frame_pos) +: 8])
        frame_pos = frame_pos + 1'b1;
      else
        frame_pos = '0;
      return 1'b0;
    end
    // Length, low byte first, then the bounds check
    if (frame_pos == HDR_BYTES) begin
      info_len  = {8'h00, rx};
      frame_pos = frame_pos + 1'b1;
      return 1'b0;
    end
    if (frame_pos == HDR_BYTES + 1) begin
      info_len[15:8] = rx;
      frame_pos = length_ok(info_len) ? POS_W'(BODY_START) : '0;
      return 1'b0;
    end
    // Tail position: good frame with saturated payload length, or bad tail
    if (frame_pos >= info_len + BODY_START - 1) begin
      frame_pos = '0;
      if (rx != model_cfg.tail_value) begin
        ev.kind = EV_BAD_TAIL;
      end else begin
        body = info_len - 1'b1;
        ev.kind = EV_GOOD;
        ev.payload_len = (body > model_cfg.head_info_len) ? body - model_cfg.head_info_len
                                                           : 16'h0000;
      end
      return 1'b1;
    end
    ev.info_byte  = rx;
    ev.info_index = 16'(frame_pos - BODY_START);
    frame_pos = frame_pos + 1'b1;
    return 1'b1;
  endfunction

  // Send one byte after a random gap; record what it should produce
  task automatic send_byte(input logic [7:0] rx, input bit typed = 1'b0,
                           input bit emits = 1'b0, input ev_t given = NO_EV);
    int unsigned gap;
    bit          hit;
    ev_t         pred;
    gap = quiet ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= rx;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
    hit = deframe_byte(rx, pred);
    if (typed) begin
      if (emits) pending_events.push_back(given);
    end else if (hit) begin
      pending_events.push_back(pred);
    end
  endtask

  // Drop valid, wait for every result, then let the pipeline empty
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      REG_SYNC_PATTERN:  model_cfg.sync_pattern  = val;
      REG_TAIL_VALUE:    model_cfg.tail_value    = val[7:0];
      REG_MAX_INFO_LEN:  model_cfg.max_info_len  = val[15:0];
      REG_MIN_INFO_LEN:  model_cfg.min_info_len  = val[15:0];
      REG_HEAD_INFO_LEN: model_cfg.head_info_len = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Emit a frame most of the time (some with a bad length or tail), else noise or a broken header
  task automatic send_chunk();
    int unsigned pick, lo, hi, bad_at, k;
    logic [15:0] len;
    logic [7:0]  want, wrong;
    pick = $urandom_range(0, 99);
    if (pick < 12) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
    end else if (pick < 22) begin
      bad_at = $urandom_range(0, 3);
      for (k = 0; k < bad_at; k++) send_byte(model_cfg.sync_pattern[8*k +: 8]);
      want = model_cfg.sync_pattern[8*bad_at +: 8];
      // Sometimes break it with the first header byte, which must not restart the hunt
      if (want != model_cfg.sync_pattern[7:0] && $urandom_range(0, 1) == 1)
        wrong = model_cfg.sync_pattern[7:0];
      else
        wrong = want ^ 8'($urandom_range(1, 255));
      send_byte(wrong);
    end else begin
      lo = (model_cfg.min_info_len == 16'h0000) ? 1 : model_cfg.min_info_len;
      hi = model_cfg.max_info_len;
      if (lo <= hi && lo <= LONGEST && $urandom_range(0, 3) != 0) begin
        len = 16'($urandom_range(lo, (hi < lo + 15) ? hi : lo + 15));
      end else begin
        case ($urandom_range(0, 3))
          0:       len = 16'h0000;
          1:       len = model_cfg.min_info_len - 1'b1;
          2:       len = model_cfg.max_info_len + 1'b1;
          default: len = 16'($urandom_range(0, 65535));
        endcase
      end
      // Keep accepted frames short
      if (length_ok(len) && len > LONGEST) len = 16'h0000;
      for (k = 0; k < HDR_BYTES; k++) send_byte(model_cfg.sync_pattern[8*k +: 8]);
      send_byte(len[7:0]);
      send_byte(len[15:8]);
      if (length_ok(len)) begin
        for (k = 1; k < len; k++) send_byte(8'($urandom_range(0, 255)));
        send_byte((pick < 90) ? model_cfg.tail_value : 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Receiver: stall a random number of cycles before each transfer
  initial begin
    int unsigned stall;
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 15);
      repeat (stall) begin
        @(negedge clk);
        out_tready <= 1'b0;
      end
      @(negedge clk);
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  // Check each result transfer against the oldest expectation
  always @(posedge clk) begin : check_results
    ev_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.kind        = event_kind_t'(out_tuser);
      got.info_byte   = out_tdata[7:0];
      got.info_index  = out_tdata[23:8];
      got.payload_len = out_tdata[39:24];
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result, expected none, got kind %0d byte %02h index %0d len %0d",
                 $time, got.kind, got.info_byte, got.info_index, got.payload_len);
        fail_count++;
      end else begin
        want = pending_events.pop_front();
        if (got.kind !== want.kind) begin
          $display("%0t: event_kind expected %0d, got %0d", $time, want.kind, got.kind);
          fail_count++;
        end
        if (got.info_byte !== want.info_byte) begin
          $display("%0t: info_byte expected %02h, got %02h", $time, want.info_byte,
                   got.info_byte);
          fail_count++;
        end
        if (got.info_index !== want.info_index) begin
          $display("%0t: info_index expected %0d, got %0d", $time, want.info_index,
                   got.info_index);
          fail_count++;
        end
        if (got.payload_len !== want.payload_len) begin
          $display("%0t: payload_len expected %0d, got %0d", $time, want.payload_len,
                   got.payload_len);
          fail_count++;
        end
      end
    end
  end

  initial begin
    int unsigned phase, phase_start;
    logic [31:0] sp;
    logic [7:0]  tv;
    logic [15:0] mx, mn, hd;

    // Predictor starts from the reset configuration
    model_cfg = '{32'h0000_0000, 8'h00, 16'hFFFF, 16'h0001, 16'h0000};
    frame_pos = '0;
    info_len  = '0;

    // Directed bytes under the reset configuration
    dir_tab = '{
      // good frame, length 2: one info byte at the top value, then the tail
      '{8'h00, 1'b0, 1'b0, NO_EV}, '{8'h00, 1'b0, 1'b0, NO_EV},
      '{8'h00, 1'b0, 1'b0, NO_EV}, '{8'h00, 1'b0, 1'b0, NO_EV},
      '{8'h02, 1'b0, 1'b0, NO_EV}, '{8'h00, 1'b0, 1'b0, NO_EV},
      '{8'hFF, 1'b1, 1'b1, '{EV_INFO, 8'hFF, 16'h0000, 16'h0000}},
      '{8'h00, 1'b1, 1'b1, '{EV_GOOD, 8'h00, 16'h0000, 16'h0001}},
      // zero length is rejected
      '{8'h00, 1'b1, 1'b0, NO_EV}, '{8'h00, 1'b1, 1'b0, NO_EV},
      '{8'h00, 1'b1, 1'b0, NO_EV}, '{8'h00, 1'b1, 1'b0, NO_EV},
      '{8'h00, 1'b1, 1'b0, NO_EV}, '{8'h00, 1'b1, 1'b0, NO_EV},
      // header miss
      '{8'h00, 1'b1, 1'b0, NO_EV}, '{8'h00, 1'b1, 1'b0, NO_EV},
      '{8'h5A, 1'b1, 1'b0, NO_EV},
      // length 1 with a wrong tail
      '{8'h00, 1'b0, 1'b0, NO_EV}, '{8'h00, 1'b0, 1'b0, NO_EV},
      '{8'h00, 1'b0, 1'b0, NO_EV}, '{8'h00, 1'b0, 1'b0, NO_EV},
      '{8'h01, 1'b0, 1'b0, NO_EV}, '{8'h00, 1'b0, 1'b0, NO_EV},
      '{8'h80, 1'b1, 1'b1, '{EV_BAD_TAIL, 8'h00, 16'h0000, 16'h0000}}
    };

    // Hold reset, release at a falling edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    quiet = ($urandom_range(0, 1) == 1);
    foreach (dir_tab[i])
      send_byte(dir_tab[i].rx, dir_tab[i].typed, dir_tab[i].emits, dir_tab[i].ev);
    drain_results();

    // Random phases, each under its own register settings
    for (phase = 0; phase < PHASES; phase++) begin
      sp = $urandom;
      tv = 8'($urandom_range(0, 255));
      mx = 16'($urandom_range(4, 30));
      mn = 16'($urandom_range(0, mx));
      hd = 16'($urandom_range(0, 12));
      case (phase)
        0: begin sp = 32'hFFFF_FFFF; tv = 8'hFF; mx = 16'hFFFF; mn = 16'h0001; hd = 16'h0000; end
        1: begin sp = 32'h5AA5_5AA5; mx = 16'd12; mn = 16'd3; hd = 16'd2; end
        2: begin sp = 32'h0000_0000; tv = 8'h00; mx = 16'h0000; mn = 16'h0000; hd = 16'h0000; end
        3: begin mx = 16'hFFFF; mn = 16'hFFFF; hd = 16'h0000; end
        4: begin mx = 16'd3; mn = 16'd5; end
        5: begin mx = 16'd20; mn = 16'd1; hd = 16'hFFFF; end
        default: ;
      endcase
      write_reg(REG_SYNC_PATTERN, sp);
      write_reg(REG_TAIL_VALUE, {24'h0, tv});
      write_reg(REG_MAX_INFO_LEN, {16'h0, mx});
      write_reg(REG_MIN_INFO_LEN, {16'h0, mn});
      write_reg(REG_HEAD_INFO_LEN, {16'h0, hd});
      if (phase == 0) write_reg(REG_SPARE, $urandom);

      quiet = ($urandom_range(0, 3) == 0);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_chunk();
      drain_results();
    end

    if (fail_count == 0) begin
      $display("header_length_tail_deframer_tb passed");
    end else begin
      $display("header_length_tail_deframer_tb failed");
    end
    $finish;
  end

endmodule
